// ===== src/tppu_pkg.sv =====
// ============================================================================
// tppu_pkg - shared types and constants of the tile video register port
// Operation codes, controller/datapath command and status words, defaults.
// ============================================================================
package tppu_pkg;

    localparam int NAME_TABLE_BYTES_DEF = 2048;
    localparam int SPRITE_BYTES_DEF     = 256;
    localparam int PALETTE_BYTES        = 32;
    localparam int PAL_AW               = 5;
    localparam int SPR_PTR_W            = 8;
    localparam int VRAM_AW              = 14;
    localparam int NT_FOLD_W            = 11;

    typedef enum logic [2:0] {
        OP_CTRL_WR = 3'd0,
        OP_OAM_ADDR = 3'd1,
        OP_OAM_WR  = 3'd2,
        OP_OAM_RD  = 3'd3,
        OP_ADDR_WR = 3'd4,
        OP_DATA_WR = 3'd5,
        OP_DATA_RD = 3'd6
    } t_op;

    typedef struct packed {
        logic clear;   // clearing pass: write zero at sweep address
        logic issue;   // word accepted: update state, launch reads
        logic finish;  // read data valid: update buffer, load result
    } t_cmd;

    typedef struct packed {
        logic clear_last; // sweep at last entry
    } t_sts;

endpackage

// ===== src/tppu_ctrl.sv =====
// ============================================================================
// tppu_ctrl - sequencer of the tile video register port
// Runs the reset clearing pass, then steps each word through issue/finish.
// ============================================================================
module tppu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tppu_pkg::t_cmd o_cmd,
    input  tppu_pkg::t_sts i_sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_DONE;
                    r_out_valid <= 1'b1;
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_in_ready   = r_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.issue  = i_in_valid & r_in_ready;
    assign o_cmd.finish = (r_state == S_EXEC);

endmodule

// ===== src/tppu_dp.sv =====
// ============================================================================
// tppu_dp - datapath of the tile video register port
// Pointers, read buffer, name table / palette / sprite memories, result reg.
// ============================================================================
module tppu_dp #(
    parameter int NAME_TABLE_BYTES = tppu_pkg::NAME_TABLE_BYTES_DEF,
    parameter int SPRITE_BYTES     = tppu_pkg::SPRITE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tppu_pkg::t_cmd i_cmd,
    output tppu_pkg::t_sts o_sts,
    input  logic           i_mirror_vertical,
    input  logic [2:0]     i_operation,
    input  logic [7:0]     i_write_byte,
    input  logic [7:0]     i_pattern_byte,
    output logic [7:0]     o_read_byte
);

    localparam int NTW = $clog2(NAME_TABLE_BYTES);
    localparam int SW  = $clog2(SPRITE_BYTES);

    typedef enum logic [1:0] {
        SRC_PAT,
        SRC_NT,
        SRC_PAL,
        SRC_NONE
    } t_src;

    logic [7:0] nt_mem  [NAME_TABLE_BYTES];
    logic [7:0] pal_mem [tppu_pkg::PALETTE_BYTES];
    logic [7:0] spr_mem [SPRITE_BYTES];

    logic [NTW-1:0]                 r_clr_cnt;
    logic [tppu_pkg::SPR_PTR_W-1:0] r_sprite_ptr;
    logic [tppu_pkg::VRAM_AW-1:0]   r_vram_ptr;
    logic                           r_low_next;
    logic                           r_step_row;
    logic [7:0]                     r_buffer;
    tppu_pkg::t_op                  r_op;
    t_src                           r_src;
    logic [7:0]                     r_pb;
    logic [7:0]                     r_out;
    logic [7:0]                     r_nt_q;
    logic [7:0]                     r_pal_q;
    logic [7:0]                     r_spr_q;

    tppu_pkg::t_op                  op;
    t_src                           src;
    logic [tppu_pkg::NT_FOLD_W-1:0] nt_fold;
    logic [tppu_pkg::PAL_AW-1:0]    pal_fold;
    logic [NTW-1:0]                 nt_addr;
    logic [tppu_pkg::PAL_AW-1:0]    pal_addr;
    logic [SW-1:0]                  spr_addr;
    logic                           nt_we;
    logic                           pal_we;
    logic                           spr_we;
    logic [7:0]                     wr_data;
    logic [tppu_pkg::VRAM_AW-1:0]   n_vram_ptr;

    assign op = tppu_pkg::t_op'(i_operation);

    // address region of the current pointer
    always_comb begin
        if (!r_vram_ptr[13])
            src = SRC_PAT;
        else if (!r_vram_ptr[12])
            src = SRC_NT;
        else if (r_vram_ptr[11:8] == 4'hF)
            src = SRC_PAL;
        else
            src = SRC_NONE;
    end

    // vertical: tables 0/1 distinct; horizontal: tables 0/1 and 2/3 pair up
    assign nt_fold  = i_mirror_vertical ? r_vram_ptr[10:0]
                                        : {r_vram_ptr[11], r_vram_ptr[9:0]};
    // sprite backdrop entries alias background ones
    assign pal_fold = ((r_vram_ptr[4:0] & 5'h13) == 5'h10)
                      ? {1'b0, r_vram_ptr[3:0]} : r_vram_ptr[4:0];

    assign nt_addr  = i_cmd.clear ? r_clr_cnt : NTW'(nt_fold);
    assign pal_addr = i_cmd.clear ? r_clr_cnt[tppu_pkg::PAL_AW-1:0] : pal_fold;
    assign spr_addr = i_cmd.clear ? r_clr_cnt[SW-1:0] : r_sprite_ptr[SW-1:0];
    assign wr_data  = i_cmd.clear ? 8'h00 : i_write_byte;

    assign nt_we  = i_cmd.clear | (i_cmd.issue && op == tppu_pkg::OP_DATA_WR
                                   && src == SRC_NT);
    assign pal_we = i_cmd.clear | (i_cmd.issue && op == tppu_pkg::OP_DATA_WR
                                   && src == SRC_PAL);
    assign spr_we = i_cmd.clear | (i_cmd.issue && op == tppu_pkg::OP_OAM_WR);

    assign n_vram_ptr = r_vram_ptr + (r_step_row ? tppu_pkg::VRAM_AW'(32)
                                                 : tppu_pkg::VRAM_AW'(1));

    assign o_sts.clear_last = (r_clr_cnt == NTW'(NAME_TABLE_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (nt_we)
            nt_mem[nt_addr] <= wr_data;
        r_nt_q <= nt_mem[nt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we)
            pal_mem[pal_addr] <= wr_data;
        r_pal_q <= pal_mem[pal_addr];
    end

    always_ff @(posedge i_clk) begin
        if (spr_we)
            spr_mem[spr_addr] <= wr_data;
        r_spr_q <= spr_mem[spr_addr];
    end

    // payload of the word in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_op  <= op;
            r_src <= src;
            r_pb  <= i_pattern_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_sprite_ptr <= '0;
            r_vram_ptr   <= '0;
            r_low_next   <= 1'b0;
            r_step_row   <= 1'b0;
            r_buffer     <= 8'h00;
            r_out        <= 8'h00;
        end else begin
            if (i_cmd.clear && !o_sts.clear_last)
                r_clr_cnt <= r_clr_cnt + NTW'(1);
            if (i_cmd.issue) begin
                unique case (op) inside
                    tppu_pkg::OP_CTRL_WR:  r_step_row   <= i_write_byte[2];
                    tppu_pkg::OP_OAM_ADDR: r_sprite_ptr <= i_write_byte;
                    tppu_pkg::OP_OAM_WR:   r_sprite_ptr <= r_sprite_ptr + 8'd1;
                    tppu_pkg::OP_ADDR_WR: begin
                        if (!r_low_next)
                            r_vram_ptr <= {i_write_byte[5:0], r_vram_ptr[7:0]};
                        else
                            r_vram_ptr <= {r_vram_ptr[13:8], i_write_byte};
                        r_low_next <= ~r_low_next;
                    end
                    tppu_pkg::OP_DATA_WR,
                    tppu_pkg::OP_DATA_RD:  r_vram_ptr <= n_vram_ptr;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                case (r_op)
                    tppu_pkg::OP_DATA_RD: begin
                        r_out <= r_buffer;
                        case (r_src)
                            SRC_PAT: r_buffer <= r_pb;
                            SRC_NT:  r_buffer <= r_nt_q;
                            SRC_PAL: r_buffer <= r_pal_q;
                            default: ;
                        endcase
                    end
                    tppu_pkg::OP_OAM_RD: r_out <= r_spr_q;
                    default:             r_out <= 8'h00;
                endcase
            end
        end
    end

    assign o_read_byte = r_out;

endmodule

// ===== src/tile_ppu_register_port.sv =====
// ============================================================================
// tile_ppu_register_port - CPU-side register port of a tile video unit
// Control, sprite memory, VRAM address latch and buffered data port.
// ============================================================================
// One input word is one CPU register access; it yields exactly one output
// word (read_byte). After reset the block runs a clearing pass over all
// NAME_TABLE_BYTES entries of the name table memory (the palette and sprite
// memories are cleared in the same sweep) and takes no input word until it
// ends. Each word then passes through accept (state update, memory
// read launched), a finish step in which the registered memory read returns
// and the read buffer updates, and a result step that presents the result
// until it is consumed. The synchronous read of the name table memory sets
// this sequence. A new word is taken once the result has been consumed.
// Name table accesses fold onto 2 KiB by the mirroring register; palette
// accesses fold to 32 entries with sprite backdrop aliasing; pattern-range
// reads buffer the pattern byte carried with the word; 0x3000-0x3EFF is
// ignored apart from the address step.
// The mirroring register may be written at any time the block is idle.
// ============================================================================
module tile_ppu_register_port #(
    parameter int NAME_TABLE_BYTES = tppu_pkg::NAME_TABLE_BYTES_DEF,
    parameter int SPRITE_BYTES     = tppu_pkg::SPRITE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: bit 0 mirror_vertical
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] write_byte, [15:8] pattern_byte
    input  logic [2:0]  s_axis_tuser,  // [2:0] operation
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [7:0] read_byte
);

    tppu_pkg::t_cmd cmd;
    tppu_pkg::t_sts sts;
    logic           r_mirror_vertical;

    // mirroring register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_vertical <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mirror_vertical <= i_cfg_data[0];
        end
    end

    tppu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tppu_dp #(
        .NAME_TABLE_BYTES (NAME_TABLE_BYTES),
        .SPRITE_BYTES     (SPRITE_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mirror_vertical (r_mirror_vertical),
        .i_operation       (s_axis_tuser),
        .i_write_byte      (s_axis_tdata[7:0]),
        .i_pattern_byte    (s_axis_tdata[15:8]),
        .o_read_byte       (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // an accepted word has its result presented once the execute state is through
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("result not presented two cycles after accept");

    // one word in flight: no accept while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // a consumed result is never repeated
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result presented twice");

    // clearing pass and datapath issue never overlap
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !cmd.issue && !cmd.finish)
        else $error("access during clearing pass");
`endif

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench - tile video register port checker
// Drives CPU register accesses into the port, predicts every read byte from
// its own copy of the video memories and pointers, and checks each result
// word in order. Runs directed corner cases, then randomized access bursts
// under both mirroring modes and several handshake pacing phases.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // unused operation code: no effect, reads back zero
    localparam logic [2:0]  OP_NONE      = 3'd7;
    localparam logic [13:0] PATTERN_TOP  = 14'h1FFF;
    localparam logic [13:0] NT_BASE      = 14'h2000;
    localparam logic [13:0] NT_TOP       = 14'h2FFF;
    localparam logic [13:0] UNUSED_BASE  = 14'h3000;
    localparam logic [13:0] PAL_BASE     = 14'h3F00;
    localparam int unsigned PHASE_WORDS  = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = 16'h0000;  // [7:0] write_byte, [15:8] pattern_byte
    logic [2:0]  s_tuser = 3'd0;      // [2:0] operation
    logic        m_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;        // [7:0] read_byte

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    tile_ppu_register_port DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predicted port state
    // ------------------------------------------------------------------
    logic [7:0]  nt_mem  [0:tppu_pkg::NAME_TABLE_BYTES_DEF-1];
    logic [7:0]  pal_mem [0:tppu_pkg::PALETTE_BYTES-1];
    logic [7:0]  spr_mem [0:tppu_pkg::SPRITE_BYTES_DEF-1];
    logic [7:0]  spr_ptr;
    logic [13:0] vaddr;
    logic        addr_low_next;
    logic [7:0]  rd_buf;
    logic        step_row;
    logic        mirror_v;

    logic [7:0]  read_bytes_due[$];
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int          idle_pct = 0;   // sender idle chance per cycle, percent
    int          stall_pct = 0;  // receiver stall chance per cycle, percent

    // name table fold: 4 KiB window onto 2 KiB by the mirroring mode
    function automatic logic [10:0] nt_slot(input logic [13:0] addr);
        logic [11:0] offset;
        offset = addr[11:0];
        if (mirror_v) begin
            if (offset[11:10] >= 2'd2)
                offset = offset - 12'h800;
        end else begin
            if (offset[11:10] == 2'd1 || offset[11:10] == 2'd2)
                offset = offset - 12'h400;
            else if (offset[11:10] == 2'd3)
                offset = offset - 12'h800;
        end
        return offset[10:0];
    endfunction

    // palette fold: sprite backdrop entries alias the background ones
    function automatic logic [4:0] pal_slot(input logic [13:0] addr);
        logic [4:0] idx;
        idx = addr[4:0];
        if ((idx & 5'h13) == 5'h10)
            idx = idx - 5'h10;
        return idx;
    endfunction

    // Applies one access to the predicted state, returns the read byte.
    function automatic logic [7:0] apply_access(input logic [2:0] op,
                                                input logic [7:0] wb,
                                                input logic [7:0] pb);
        logic [7:0]  rb;
        logic [13:0] addr;
        rb = 8'h00;
        addr = vaddr;
        case (op)
            tppu_pkg::OP_CTRL_WR:  step_row = wb[2];
            tppu_pkg::OP_OAM_ADDR: spr_ptr = wb;
            tppu_pkg::OP_OAM_WR: begin
                spr_mem[spr_ptr] = wb;
                spr_ptr = spr_ptr + 8'd1;
            end
            tppu_pkg::OP_OAM_RD:   rb = spr_mem[spr_ptr];
            tppu_pkg::OP_ADDR_WR: begin
                if (!addr_low_next)
                    vaddr = {wb[5:0], vaddr[7:0]};
                else
                    vaddr = {vaddr[13:8], wb};
                addr_low_next = ~addr_low_next;
            end
            tppu_pkg::OP_DATA_WR: begin
                vaddr = vaddr + (step_row ? 14'd32 : 14'd1);
                if (addr >= NT_BASE && addr <= NT_TOP)
                    nt_mem[nt_slot(addr)] = wb;
                else if (addr >= PAL_BASE)
                    pal_mem[pal_slot(addr)] = wb;
            end
            tppu_pkg::OP_DATA_RD: begin
                rb = rd_buf;
                vaddr = vaddr + (step_row ? 14'd32 : 14'd1);
                if (addr <= PATTERN_TOP)
                    rd_buf = pb;
                else if (addr <= NT_TOP)
                    rd_buf = nt_mem[nt_slot(addr)];
                else if (addr >= PAL_BASE)
                    rd_buf = pal_mem[pal_slot(addr)];
            end
            default: ;
        endcase
        return rb;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one access word; the prediction is queued at acceptance.
    task automatic issue_access(input logic [2:0] op, input logic [7:0] wb,
                                input logic [7:0] pb);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pb, wb};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        read_bytes_due.push_back(apply_access(op, wb, pb));
        words_sent++;
    endtask

    // Drops valid and waits until every predicted word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (read_bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mirror(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        mirror_v = mode;
    endtask

    // Loads the VRAM address latch; usually realigns the latch first.
    task automatic set_address(input logic [13:0] addr);
        logic [1:0] junk;
        junk = 2'($urandom_range(3));
        if (addr_low_next && $urandom_range(7) != 0)
            issue_access(tppu_pkg::OP_ADDR_WR, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        issue_access(tppu_pkg::OP_ADDR_WR, {junk, addr[13:8]},
                     8'($urandom_range(255)));
        issue_access(tppu_pkg::OP_ADDR_WR, addr[7:0], 8'($urandom_range(255)));
    endtask

    function automatic logic [13:0] pick_address();
        case ($urandom_range(9)) inside
            0, 1:    return 14'($urandom_range(PATTERN_TOP));
            2, 3, 4: return NT_BASE + 14'($urandom_range(12'hFFF));
            5, 6:    return PAL_BASE + 14'($urandom_range(8'hFF));
            7:       return UNUSED_BASE + 14'($urandom_range(12'hEFF));
            default: return 14'h3FE0 + 14'($urandom_range(31));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (read_bytes_due.size() == 0) begin
                $error("unexpected result word, read_byte %02h", m_axis_tdata);
                mismatches++;
            end else begin
                logic [7:0] want;
                want = read_bytes_due.pop_front();
                words_checked++;
                if (m_axis_tdata !== want) begin
                    $error("read_byte mismatch: expected %02h actual %02h",
                           want, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    // receiver pacing
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // OAM pointer wrap at 0xFF and the non-stepping OAM read
    task automatic test_sprite_memory();
        issue_access(tppu_pkg::OP_OAM_ADDR, 8'hFF, 8'h00);
        issue_access(tppu_pkg::OP_OAM_WR, 8'hA5, 8'hFF);
        issue_access(tppu_pkg::OP_OAM_RD, 8'h00, 8'h00);
        issue_access(tppu_pkg::OP_OAM_ADDR, 8'hFF, 8'hFF);
        issue_access(tppu_pkg::OP_OAM_RD, 8'hFF, 8'h00);
    endtask

    // high byte bits 7..6 dropped, 14-bit wrap, pattern reads, step select
    task automatic test_address_stepping();
        issue_access(tppu_pkg::OP_CTRL_WR, 8'hFB, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'hFF, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'hFF, 8'h00);
        issue_access(tppu_pkg::OP_DATA_WR, 8'h5A, 8'h00);  // 0x3FFF, wraps to 0
        issue_access(tppu_pkg::OP_DATA_RD, 8'h00, 8'hFF);  // pattern byte buffered
        issue_access(tppu_pkg::OP_CTRL_WR, 8'h04, 8'hFF);  // step by a row
        issue_access(tppu_pkg::OP_DATA_RD, 8'hFF, 8'h00);
    endtask

    // sprite backdrop alias, then the unused range leaving the buffer alone
    task automatic test_palette_and_unused();
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h3F, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h10, 8'h00);
        issue_access(tppu_pkg::OP_DATA_WR, 8'h3C, 8'h00);  // 0x3F10 -> entry 0
        issue_access(tppu_pkg::OP_DATA_RD, 8'h00, 8'h00);  // 0x3F30 -> entry 0
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h30, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h00, 8'h00);
        issue_access(tppu_pkg::OP_DATA_RD, 8'h00, 8'h99);
        issue_access(OP_NONE, 8'hFF, 8'hFF);
    endtask

    // vertical mirroring: 0x2C00 and 0x2400 share one slot
    task automatic test_name_table_mirroring();
        wait_idle();
        write_mirror(1'b1);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h2C, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h00, 8'h00);
        issue_access(tppu_pkg::OP_DATA_WR, 8'h77, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h24, 8'h00);
        issue_access(tppu_pkg::OP_ADDR_WR, 8'h00, 8'h00);
        issue_access(tppu_pkg::OP_DATA_RD, 8'h00, 8'h00);
        issue_access(tppu_pkg::OP_DATA_RD, 8'h00, 8'h00);
        wait_idle();
    endtask

    // Bursts of well-formed access sequences with random content, plus noise.
    task automatic test_random_traffic(input logic mode, input int idle,
                                       input int stall);
        int unsigned target;
        int unsigned count;
        logic [13:0] addr;
        wait_idle();
        write_mirror(mode);
        idle_pct  = idle;
        stall_pct = stall;
        target = words_sent + PHASE_WORDS;
        while (words_sent < target) begin
            count = $urandom_range(1, 8);
            case ($urandom_range(9)) inside
                0, 1, 2, 3: begin
                    // write a run, come back and read it out
                    addr = pick_address();
                    set_address(addr);
                    repeat (count)
                        issue_access(tppu_pkg::OP_DATA_WR, 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                    set_address(addr);
                    repeat (count + 1)
                        issue_access(tppu_pkg::OP_DATA_RD, 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                end
                4, 5: begin
                    set_address(pick_address());
                    repeat (count)
                        issue_access($urandom_range(1) ? tppu_pkg::OP_DATA_RD
                                                       : tppu_pkg::OP_DATA_WR,
                                     8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                6, 7: begin
                    addr[7:0] = 8'($urandom_range(255));
                    issue_access(tppu_pkg::OP_OAM_ADDR, addr[7:0],
                                 8'($urandom_range(255)));
                    repeat (count)
                        issue_access(tppu_pkg::OP_OAM_WR, 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                    issue_access(tppu_pkg::OP_OAM_ADDR, addr[7:0],
                                 8'($urandom_range(255)));
                    repeat (count)
                        issue_access($urandom_range(3) != 0 ? tppu_pkg::OP_OAM_RD
                                                            : tppu_pkg::OP_OAM_WR,
                                     8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                8:
                    issue_access(tppu_pkg::OP_CTRL_WR, 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
                default:
                    repeat (count)
                        issue_access(3'($urandom_range(7)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
            endcase
        end
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (nt_mem[i]) nt_mem[i] = 8'h00;
        foreach (pal_mem[i]) pal_mem[i] = 8'h00;
        foreach (spr_mem[i]) spr_mem[i] = 8'h00;
        spr_ptr = 8'h00;
        vaddr = 14'h0000;
        addr_low_next = 1'b0;
        rd_buf = 8'h00;
        step_row = 1'b0;
        mirror_v = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // block clears its memories after reset; handshakes absorb that
        write_mirror(1'b0);
        test_sprite_memory();
        test_address_stepping();
        test_palette_and_unused();
        test_name_table_mirroring();

        test_random_traffic(1'b0, 0, 0);
        test_random_traffic(1'b1, 75, 0);
        test_random_traffic(1'b0, 0, 75);
        test_random_traffic(1'b1, 36, 36);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (read_bytes_due.size() != 0) begin
            $error("%0d result words never arrived", read_bytes_due.size());
            mismatches++;
        end

        $display("Sent %0d register accesses over both mirroring modes and four pacing phases;",
                 words_sent);
        $display("checked %0d read bytes, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
